[hdl/erz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler ZXY rotation package
// Shared payload types, register indexes and the quarter-wave sine function
// used to fill the sine tables at elaboration.
// ----------------------------------------------------------------------------
package erz_pkg;

  // Vector component width (signed Q16.16).
  localparam int VEC_W = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 2'd2;

  // Cycles from an angle register update until the matrix registers hold it.
  localparam int MAT_LAT = 5;

  // pi/2 in Q2.30 and the Taylor term divisors (2k)(2k+1).
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

  // One input item.
  typedef struct packed {
    logic signed [VEC_W-1:0] in_x;
    logic signed [VEC_W-1:0] in_y;
    logic signed [VEC_W-1:0] in_z;
  } in_t;

  // One result item.
  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    saturated;
  } out_t;

  // Quarter-wave sine sample r, evaluated only for constant table entries.
  // The angle is formed in Q2.30 and the odd Taylor series runs through t^17.
  function automatic longint quarter_sine(input longint unsigned r, input int abits,
                                          input int fbits);
    longint unsigned quarter;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    quarter = 64'd1 << (abits - 2);
    t       = (r * PI_HALF_Q30 + (quarter >> 1)) >> (abits - 2);
    t2      = (t * t) >> 30;
    term    = t;
    sum     = longint'(t);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * t2) >> 30) / SIN_DIV[k-1];
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    return (sum + (64'sd1 <<< (29 - fbits))) >>> (30 - fbits);
  endfunction

endpackage

[hdl/euler_zxy_rotate_vector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler ZXY vector rotation
// Rotates a Q16.16 row vector by M = Rz * Rx * Ry built from three angles.
// ----------------------------------------------------------------------------
// Usage:
//   Angles are written through cfg_we_i / cfg_idx_i / cfg_data_i while no item
//   is in flight. Index 0 is the x angle, 1 is y, 2 is z; other indexes are
//   ignored. A full turn is 2**ANGLE_BITS units.
//   An item is taken at a clock edge where start is high and busy is low.
//   Its result is on out_o with out_valid_o high for one cycle, once the item
//   has passed the input, product, sum and output registers.
//   One item can be taken every cycle while busy is low.
//   The matrix pipeline (table read, sign, two multiplier stages, rounding)
//   must follow each angle write; busy is high while it settles after every
//   write and after reset.
//   Reset clears the angles, so the matrix is the identity.
//   The receiver cannot stall: each result is shown for exactly one cycle.
//   saturated is set when any output component was clipped to 32 bits.
// ----------------------------------------------------------------------------
module euler_zxy_rotate_vector #(
  parameter int ANGLE_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [erz_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ANGLE_BITS-1:0]          cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  erz_pkg::in_t                   in_i,
  output logic                           out_valid_o,
  output erz_pkg::out_t                  out_o
);
  import erz_pkg::*;

  localparam int MW    = FRAC_BITS + 3;
  localparam int PW    = VEC_W + MW;
  localparam int AW    = PW + 2;
  localparam int RW    = AW - FRAC_BITS;
  localparam int CNT_W = $clog2(MAT_LAT + 1);
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);

  // Angle registers.
  logic [ANGLE_BITS-1:0] ang_x_q, ang_y_q, ang_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ANGLE_X: ang_x_q <= cfg_data_i;
        REG_ANGLE_Y: ang_y_q <= cfg_data_i;
        REG_ANGLE_Z: ang_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold off items until the matrix pipeline has caught up.
  logic [CNT_W-1:0] settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= CNT_W'(MAT_LAT);
    end else if (cfg_we_i) begin
      settle_q <= CNT_W'(MAT_LAT);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  assign busy = (settle_q != '0);

  // Matrix.
  logic signed [MW-1:0] m [3][3];

  erz_matrix #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk_i(clk_i), .ang_x_i(ang_x_q), .ang_y_i(ang_y_q), .ang_z_i(ang_z_q), .m_o(m));

  // Valid bits travel with the item through the four stages.
  logic       accept;
  logic [3:0] vld_q;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], accept};
    end
  end

  // Input register.
  in_t in_q;

  always_ff @(posedge clk_i) begin
    in_q <= in_i;
  end

  logic signed [VEC_W-1:0] vec [3];

  assign vec[0] = in_q.in_x;
  assign vec[1] = in_q.in_y;
  assign vec[2] = in_q.in_z;

  // Nine products v_i * M(i,j).
  logic signed [PW-1:0] prod_q [3][3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[i][j] <= vec[i] * m[i][j];
      end
    end
  end

  // Column sums with the rounding half added.
  logic signed [AW-1:0] acc_q [3];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      acc_q[j] <= AW'(prod_q[0][j]) + AW'(prod_q[1][j]) + AW'(prod_q[2][j]) + HALF;
    end
  end

  // Drop the fraction and clip each component to 32 bits.
  logic signed [RW-1:0]    rsh  [3];
  logic [VEC_W-1:0]        comp [3];
  logic [2:0]              clip;
  out_t                    out_d;
  out_t                    out_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rsh[j]  = RW'(acc_q[j] >>> FRAC_BITS);
      clip[j] = !((rsh[j][RW-1:VEC_W-1] == '0) || (rsh[j][RW-1:VEC_W-1] == '1));
      if (clip[j]) begin
        comp[j] = rsh[j][RW-1] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
      end else begin
        comp[j] = rsh[j][VEC_W-1:0];
      end
    end
    out_d.out_x     = comp[0];
    out_d.out_y     = comp[1];
    out_d.out_z     = comp[2];
    out_d.saturated = |clip;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o       = out_q;
  assign out_valid_o = vld_q[3];

  // A write always holds off items while the matrix settles.
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("busy not raised after an angle write");

  // Every accepted item gives a result after the input, product, sum and output registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 out_valid_o)
    else $error("result missing for an accepted item");

  // No result appears without an accepted item behind it in those registers.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, 4))
    else $error("result without an accepted item");

endmodule

[hdl/erz_sin_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine and cosine lookup
// Quarter-wave table with two registered read ports; the quadrant sign is
// applied in a second register stage.
// ----------------------------------------------------------------------------
module erz_sin_rom #(
  parameter int ANGLE_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic [ANGLE_BITS-1:0]        angle_i,
  output logic signed [FRAC_BITS+1:0]  sin_o,
  output logic signed [FRAC_BITS+1:0]  cos_o
);
  import erz_pkg::*;

  localparam int QW      = ANGLE_BITS - 2;
  localparam int QUARTER = 1 << QW;
  localparam int AW      = ANGLE_BITS - 1;
  localparam int MAGW    = FRAC_BITS + 1;
  localparam int SW      = FRAC_BITS + 2;

  // Constant quarter-wave table, one entry per sample from 0 to a quarter turn.
  logic [MAGW-1:0] rom [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign rom[g] = MAGW'(quarter_sine(64'(g), ANGLE_BITS, FRAC_BITS));
  end

  // Port 0 reads the sine, port 1 the sine a quarter turn later.
  logic [ANGLE_BITS-1:0] ang [2];
  logic [AW-1:0]         addr [2];
  logic [MAGW-1:0]       mag_q [2];
  logic                  neg_q [2];
  logic signed [SW-1:0]  val_q [2];

  assign ang[0] = angle_i;
  assign ang[1] = angle_i + ANGLE_BITS'(QUARTER);

  // Odd quadrants read the table backward.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      if (ang[p][QW]) begin
        addr[p] = AW'(QUARTER) - AW'(ang[p][QW-1:0]);
      end else begin
        addr[p] = AW'(ang[p][QW-1:0]);
      end
    end
  end

  // Table read, then sign for the lower half of the wave.
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 2; p++) begin
      mag_q[p] <= rom[addr[p]];
      neg_q[p] <= ang[p][ANGLE_BITS-1];
      val_q[p] <= neg_q[p] ? -$signed({1'b0, mag_q[p]}) : $signed({1'b0, mag_q[p]});
    end
  end

  assign sin_o = val_q[0];
  assign cos_o = val_q[1];

endmodule

[hdl/erz_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix builder
// Forms M = Rz * Rx * Ry from the three angles, each entry exact and then
// rounded to nearest, ties up. Fully pipelined.
// ----------------------------------------------------------------------------
module erz_matrix #(
  parameter int ANGLE_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic [ANGLE_BITS-1:0]       ang_x_i,
  input  logic [ANGLE_BITS-1:0]       ang_y_i,
  input  logic [ANGLE_BITS-1:0]       ang_z_i,
  output logic signed [FRAC_BITS+2:0] m_o [3][3]
);
  import erz_pkg::*;

  localparam int SW = FRAC_BITS + 2;
  localparam int PW = 2 * SW;
  localparam int TW = 3 * SW + 1;
  localparam int MW = FRAC_BITS + 3;
  localparam logic signed [SW-1:0] ONE  = SW'(1) <<< FRAC_BITS;
  localparam logic signed [TW-1:0] HALF = TW'(1) <<< (2 * FRAC_BITS - 1);

  logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;

  erz_sin_rom #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_rom_x (
    .clk_i(clk_i), .angle_i(ang_x_i), .sin_o(sx), .cos_o(cx));
  erz_sin_rom #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_rom_y (
    .clk_i(clk_i), .angle_i(ang_y_i), .sin_o(sy), .cos_o(cy));
  erz_sin_rom #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_rom_z (
    .clk_i(clk_i), .angle_i(ang_z_i), .sin_o(sz), .cos_o(cz));

  // Two-factor products of every entry, plus the partial products sz*sx and
  // cz*sx that feed the three-factor terms.
  logic signed [PW-1:0] p2_d [9];
  logic signed [PW-1:0] p2_q [9];
  logic signed [PW-1:0] szsx_q, czsx_q;
  logic signed [SW-1:0] sy_q, cy_q;

  always_comb begin
    p2_d[0] = cz * cy;
    p2_d[1] = -(sz * cx);
    p2_d[2] = cz * sy;
    p2_d[3] = sz * cy;
    p2_d[4] = cz * cx;
    p2_d[5] = sz * sy;
    p2_d[6] = -(cx * sy);
    p2_d[7] = sx * ONE;
    p2_d[8] = cx * cy;
  end

  always_ff @(posedge clk_i) begin
    p2_q   <= p2_d;
    szsx_q <= sz * sx;
    czsx_q <= cz * sx;
    sy_q   <= sy;
    cy_q   <= cy;
  end

  // Three-factor terms; entries without one carry zero.
  logic signed [PW-1:0] p2d_q [9];
  logic signed [TW-1:0] tri_q [9];

  always_ff @(posedge clk_i) begin
    p2d_q    <= p2_q;
    tri_q[0] <= -(szsx_q * sy_q);
    tri_q[1] <= '0;
    tri_q[2] <= szsx_q * cy_q;
    tri_q[3] <= czsx_q * sy_q;
    tri_q[4] <= '0;
    tri_q[5] <= -(czsx_q * cy_q);
    tri_q[6] <= '0;
    tri_q[7] <= '0;
    tri_q[8] <= '0;
  end

  // Align both terms at 3*FRAC_BITS fractional bits and round to FRAC_BITS.
  logic signed [TW-1:0] total [9];
  logic signed [MW-1:0] m_q   [9];

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      total[e] = (TW'(p2d_q[e]) <<< FRAC_BITS) + tri_q[e] + HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 9; e++) begin
      m_q[e] <= MW'(total[e] >>> (2 * FRAC_BITS));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_o[i][j] = m_q[3 * i + j];
      end
    end
  end

endmodule

[tb/euler_zxy_rotate_vector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler ZXY vector rotation testbench
// Writes sets of three angles through the write port and streams Q16.16
// vectors into the block. Random vectors go in bursts with random gaps.
// A rotation predictor builds its own sine values, matrix and rounding, and
// checks every result in order against the block.
// ----------------------------------------------------------------------------
module euler_zxy_rotate_vector_tb;
  import erz_pkg::*;

  localparam int ABITS = 12;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int N_RANDOM = 1300;

  // Predicts the rotated vectors and holds those not yet seen on the output.
  class rotation_tracker;
    logic [ABITS-1:0] angle[3];
    longint mat[3][3];
    out_t expected_q[$];
    int errors;

    function new();
      angle = '{default: '0};
      errors = 0;
      rebuild();
    endfunction

    // Quarter-wave sine in Q1.16, from a Taylor series summed in Q2.30.
    function longint quarter_wave(longint unsigned r);
      longint unsigned t, t2, term;
      longint sum;
      t = (r * 64'd1686629713 + 64'd512) >> 10;
      t2 = (t * t) >> 30;
      term = t;
      sum = longint'(t);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum -= longint'(term);
        end else begin
          sum += longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      return (sum + (64'sd1 <<< 13)) >>> 14;
    endfunction

    function longint sine_of(int a);
      int quad, r;
      longint v;
      a = a % 4096;
      quad = a / 1024;
      r = a % 1024;
      if (quad % 2 == 1) r = 1024 - r;
      v = quarter_wave(r);
      return (quad >= 2) ? -v : v;
    endfunction

    // Sum exact in units of 2^-48, rounded to 16 fractional bits, ties up.
    function longint round48(longint v);
      return (v + (64'sd1 <<< 31)) >>> 32;
    endfunction

    function void rebuild();
      longint sx, cx, sy, cy, sz, cz;
      sx = sine_of(angle[0]); cx = sine_of(angle[0] + 1024);
      sy = sine_of(angle[1]); cy = sine_of(angle[1] + 1024);
      sz = sine_of(angle[2]); cz = sine_of(angle[2] + 1024);
      mat[0][0] = round48(((cz * cy) <<< 16) - sz * sx * sy);
      mat[0][1] = round48((-sz * cx) <<< 16);
      mat[0][2] = round48(((cz * sy) <<< 16) + sz * sx * cy);
      mat[1][0] = round48(((sz * cy) <<< 16) + cz * sx * sy);
      mat[1][1] = round48((cz * cx) <<< 16);
      mat[1][2] = round48(((sz * sy) <<< 16) - cz * sx * cy);
      mat[2][0] = round48((-cx * sy) <<< 16);
      mat[2][1] = round48((sx <<< 16) <<< 16);
      mat[2][2] = round48((cx * cy) <<< 16);
    endfunction

    function void set_angle(logic [CFG_IDX_W-1:0] idx, logic [ABITS-1:0] val);
      if (idx == REG_ANGLE_X) angle[0] = val;
      else if (idx == REG_ANGLE_Y) angle[1] = val;
      else if (idx == REG_ANGLE_Z) angle[2] = val;
      else return;
      rebuild();
    endfunction

    // Notes an accepted item and queues the rotated vector it must produce.
    function void note_item(in_t v);
      longint comp[3], acc, r;
      logic signed [31:0] res[3];
      out_t e;
      comp[0] = longint'(v.in_x);
      comp[1] = longint'(v.in_y);
      comp[2] = longint'(v.in_z);
      e.saturated = 1'b0;
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc += comp[i] * mat[i][j];
        r = (acc + (64'sd1 <<< 15)) >>> 16;
        if (r > 64'sd2147483647) begin
          r = 64'sd2147483647;
          e.saturated = 1'b1;
        end else if (r < -64'sd2147483648) begin
          r = -64'sd2147483648;
          e.saturated = 1'b1;
        end
        res[j] = r[31:0];
      end
      e.out_x = res[0];
      e.out_y = res[1];
      e.out_z = res[2];
      expected_q.push_back(e);
    endfunction

    // Compares one result with the oldest expected vector.
    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.out_x !== e.out_x) begin
        $display("%0t: out_x expected %0d got %0d", $time, e.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== e.out_y) begin
        $display("%0t: out_y expected %0d got %0d", $time, e.out_y, got.out_y);
        errors++;
      end
      if (got.out_z !== e.out_z) begin
        $display("%0t: out_z expected %0d got %0d", $time, e.out_z, got.out_z);
        errors++;
      end
      if (got.saturated !== e.saturated) begin
        $display("%0t: saturated expected %b got %b", $time, e.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ABITS-1:0] cfg_data_i;
  logic start;
  logic busy;
  in_t in_i;
  logic out_valid_o;
  out_t out_o;

  rotation_tracker tracker;
  int idle_cycles = 0;

  euler_zxy_rotate_vector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Checks results, notes accepted items and watches for a stuck block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o) tracker.check_result(out_o);
      if (start && !busy) tracker.note_item(in_i);
      if (out_valid_o || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("euler_zxy_rotate_vector_tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_item(in_t v);
    logic ready;
    start <= 1'b1;
    in_i <= v;
    forever begin
      @(negedge clk_i);
      ready = !busy;
      @(posedge clk_i);
      if (ready) break;
    end
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits until every expected vector has come out.
  task automatic drain();
    start <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (MAT_LAT) @(posedge clk_i);
  endtask

  task automatic write_angle(logic [CFG_IDX_W-1:0] idx, logic [ABITS-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_angle(idx, val);
  endtask

  task automatic set_angles(logic [ABITS-1:0] ax, logic [ABITS-1:0] ay,
                            logic [ABITS-1:0] az);
    drain();
    write_angle(REG_ANGLE_X, ax);
    write_angle(REG_ANGLE_Y, ay);
    write_angle(REG_ANGLE_Z, az);
  endtask

  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 32'h0003_ffff)) - 32'h0002_0000;
      3: return {{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ABITS-1:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return ABITS'($urandom_range(0, 3) * 1024);
      default: return ABITS'($urandom);
    endcase
  endfunction

  function automatic in_t vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    return v;
  endfunction

  initial begin
    int sent;
    int burst;
    tracker = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ANGLE_X;
    cfg_data_i = '0;
    start = 1'b0;
    in_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity after reset: extremes pass straight through.
    send_item(vec(32'h7fff_ffff, 32'h8000_0000, 32'h0));
    send_item(vec(32'h0, 32'hffff_ffff, 32'h0001_0000));
    send_item(vec(32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000));

    // Quarter and half turns, then odd angles that make the matrix irrational.
    set_angles(12'd1024, 12'd2048, 12'd3072);
    send_item(vec(32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
    send_item(vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    set_angles(12'd512, 12'd512, 12'd512);
    send_item(vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_item(vec(32'h0000_0001, 32'hffff_ffff, 32'h0000_8000));
    set_angles(12'd4095, 12'd4095, 12'd4095);
    send_item(vec(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678));
    send_item(vec(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));

    // A write to the unused index must leave the matrix alone.
    drain();
    write_angle(REG_UNUSED, 12'd777);
    send_item(vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    set_angles(12'd1, 12'd0, 12'd2047);
    send_item(vec(32'h4000_0000, 32'hc000_0000, 32'h0));

    // Random phases: new angles, then vectors in bursts with random gaps.
    sent = 0;
    while (sent < N_RANDOM) begin
      set_angles(pick_angle(), pick_angle(), pick_angle());
      for (int n = 0; n < 130 && sent < N_RANDOM; ) begin
        burst = $urandom_range(1, 30);
        for (int b = 0; b < burst; b++) begin
          send_item(vec(pick_component(), pick_component(), pick_component()));
          n++;
          sent++;
        end
        if ($urandom_range(0, 19) == 0) drain();
        else if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("euler_zxy_rotate_vector_tb OK");
    end else begin
      $display("euler_zxy_rotate_vector_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/erz_pkg.sv
hdl/erz_sin_rom.sv
hdl/erz_matrix.sv
hdl/euler_zxy_rotate_vector.sv
tb/euler_zxy_rotate_vector_tb.sv
